[src/fsd_pkg.sv]
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared constants, types and helpers for the Floyd-Steinberg dither block.
// ----------------------------------------------------------------------------
`default_nettype none

package fsd_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int FRAC_BITS_DEF  = 8;

   localparam int PIXEL_W        = 8;
   localparam int IMAGE_WIDTH_W  = 12;
   localparam int BIT_DEPTH_W    = 4;

   localparam int CSR_INDEX_W    = 4;
   localparam int CSR_DATA_W     = 16;

   localparam int IMAGE_WIDTH_RESET = 2048;
   localparam int BIT_DEPTH_RESET   = 1;
   localparam int BIT_DEPTH_MAX     = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_DEPTH   = CSR_INDEX_W'(1);

   typedef struct packed {
      logic frame_start;
      logic first_row;
      logic row_end;
   } item_flags_type;

   // keep the top b bits of q and repeat them down through the low bits
   function automatic logic [PIXEL_W-1:0] fsd_rebuild(input logic [PIXEL_W-1:0] q,
                                                      input logic [BIT_DEPTH_W-1:0] b);
      logic [PIXEL_W-1:0] mask;
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] r;
      int                 s;
      mask = 8'hFF << (4'd8 - b);
      top  = q & mask;
      r    = top;
      for (s = 1; s <= PIXEL_W; s++) begin
         if (s * int'(b) <= PIXEL_W) begin
            r = r | (top >> (s * int'(b)));
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[src/fsd_csr.sv]
// ----------------------------------------------------------------------------
// fsd_csr
// Configuration registers; values are stored already clamped to legal range.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_csr #(
   parameter int MAX_WIDTH = fsd_pkg::MAX_WIDTH_DEF,
   localparam int COL_W    = $clog2(MAX_WIDTH),
   localparam int WID_W    = COL_W + 1
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [fsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fsd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic [WID_W-1:0]                     width_eff,
   output logic [fsd_pkg::BIT_DEPTH_W-1:0]      depth_eff
);
   import fsd_pkg::*;

   localparam int CMP_W = (WID_W > IMAGE_WIDTH_W) ? WID_W : IMAGE_WIDTH_W;
   localparam int WIDTH_RESET = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                 : IMAGE_WIDTH_RESET;

   logic [WID_W-1:0]       width_ff, width_in;
   logic [BIT_DEPTH_W-1:0] depth_ff, depth_in;
   logic [CMP_W-1:0]       wd_ext;
   logic [BIT_DEPTH_W-1:0] dd;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in = width_ff;
      depth_in = depth_ff;
      wd_ext   = CMP_W'(csr_wdata[IMAGE_WIDTH_W-1:0]);
      dd       = csr_wdata[BIT_DEPTH_W-1:0];
      if (csr_valid && csr_ready && csr_index == CSR_IMAGE_WIDTH) begin
         priority if (wd_ext == '0) begin
            width_in = WID_W'(1);
         end else if (wd_ext > CMP_W'(MAX_WIDTH)) begin
            width_in = WID_W'(MAX_WIDTH);
         end else begin
            width_in = wd_ext[WID_W-1:0];
         end
      end
      if (csr_valid && csr_ready && csr_index == CSR_BIT_DEPTH) begin
         priority if (dd == '0) begin
            depth_in = BIT_DEPTH_W'(1);
         end else if (dd > BIT_DEPTH_W'(BIT_DEPTH_MAX)) begin
            depth_in = BIT_DEPTH_W'(BIT_DEPTH_MAX);
         end else begin
            depth_in = dd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WID_W'(WIDTH_RESET);
         depth_ff <= BIT_DEPTH_W'(BIT_DEPTH_RESET);
      end else begin
         width_ff <= width_in;
         depth_ff <= depth_in;
      end
   end

   assign width_eff = width_ff;
   assign depth_eff = depth_ff;

endmodule

`default_nettype wire

[src/fsd_front.sv]
// ----------------------------------------------------------------------------
// fsd_front
// Column counter and first-row flag, stepped once per accepted input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_front #(
   parameter int MAX_WIDTH = fsd_pkg::MAX_WIDTH_DEF,
   localparam int COL_W    = $clog2(MAX_WIDTH),
   localparam int WID_W    = COL_W + 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               frame_start,
   input  wire logic [WID_W-1:0]   width_eff,
   output logic [COL_W-1:0]        col,
   output fsd_pkg::item_flags_type flags
);
   import fsd_pkg::*;

   logic [COL_W-1:0] col_ff, col_in;
   logic             first_row_ff, first_row_in;
   logic             row_end;
   logic             first_row;

   always_comb begin
      col       = frame_start ? '0 : col_ff;
      first_row = frame_start | first_row_ff;
      row_end   = (WID_W'(col) + WID_W'(1)) >= width_eff;

      flags.frame_start = frame_start;
      flags.first_row   = first_row;
      flags.row_end     = row_end;

      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (accept) begin
         if (row_end) begin
            col_in       = '0;
            first_row_in = 1'b0;
         end else begin
            col_in       = col + COL_W'(1);
            first_row_in = first_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
      end else begin
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
      end
   end

endmodule

`default_nettype wire

[src/fsd_row_ram.sv]
// ----------------------------------------------------------------------------
// fsd_row_ram
// Row error store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_row_ram #(
   parameter int DEPTH  = fsd_pkg::MAX_WIDTH_DEF,
   parameter int DATA_W = fsd_pkg::FRAC_BITS_DEF + 10,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0]      rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/fsd_diffuse.sv]
// ----------------------------------------------------------------------------
// fsd_diffuse
// Quantize stage: adds diffused error, quantizes, spreads the residual and
// writes row errors back, with bypass for entries still in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_diffuse #(
   parameter int COL_W     = $clog2(fsd_pkg::MAX_WIDTH_DEF),
   parameter int FRAC_BITS = fsd_pkg::FRAC_BITS_DEF,
   localparam int ERR_W    = FRAC_BITS + 10,
   localparam int ACC_W    = FRAC_BITS + 11
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   output logic                                 in_ready,
   input  wire logic [COL_W-1:0]                in_col,
   input  wire fsd_pkg::item_flags_type         in_flags,
   input  wire logic [fsd_pkg::PIXEL_W-1:0]     in_pixel,
   input  wire logic [fsd_pkg::BIT_DEPTH_W-1:0] depth,
   input  wire logic [ERR_W-1:0]                ram_rd_data,
   output logic                                 ram_wr_en,
   output logic [COL_W-1:0]                     ram_wr_addr,
   output logic [ERR_W-1:0]                     ram_wr_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [fsd_pkg::PIXEL_W-1:0]          rsp_pixel_out
);
   import fsd_pkg::*;

   localparam int QW = FRAC_BITS + PIXEL_W;
   localparam logic signed [ACC_W-1:0] TOP_ACC = ACC_W'(255 << FRAC_BITS);
   localparam logic [QW-1:0] HALF = QW'(1 << (FRAC_BITS - 1));

   // stage registers
   logic                      a_valid_ff, a_valid_in;
   logic [PIXEL_W-1:0]        a_pixel_ff, a_pixel_in;
   logic [COL_W-1:0]          a_col_ff, a_col_in;
   item_flags_type            a_flags_ff, a_flags_in;
   logic                      byp_hit_ff, byp_hit_in;
   logic signed [ERR_W-1:0]   byp_data_ff, byp_data_in;

   // carried errors
   logic signed [ERR_W-1:0]   re_ff, re_in;
   logic signed [ERR_W-1:0]   bl_ff, bl_in;
   logic signed [ERR_W-1:0]   bp_ff, bp_in;

   // deferred row-end write
   logic                      pend_valid_ff, pend_valid_in;
   logic [COL_W-1:0]          pend_addr_ff, pend_addr_in;
   logic signed [ERR_W-1:0]   pend_data_ff, pend_data_in;

   // output register
   logic                      out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0]        out_pixel_ff, out_pixel_in;

   logic                      a_adv;
   logic signed [ERR_W-1:0]   re_cur, bl_cur, bp_cur, row_err;
   logic signed [ACC_W-1:0]   acc;
   logic [QW-1:0]             acc_c;
   logic [QW-1:0]             round_sum;
   logic [PIXEL_W-1:0]        colour;
   logic signed [ERR_W-1:0]   err;
   logic signed [ERR_W+2:0]   ex, m7, m5, m3, m7_sh, m5_sh, m3_sh;
   logic signed [ERR_W-1:0]   e7, e5, e3, e1;
   logic signed [ERR_W-1:0]   prim_data, tail_data;
   logic                      prim_we;
   logic [COL_W-1:0]          prim_addr;

   always_comb begin
      a_adv    = a_valid_ff && (!out_valid_ff || rsp_ready);
      in_ready = !a_valid_ff || a_adv;

      re_cur  = a_flags_ff.frame_start ? '0 : re_ff;
      bl_cur  = a_flags_ff.frame_start ? '0 : bl_ff;
      bp_cur  = a_flags_ff.frame_start ? '0 : bp_ff;
      row_err = a_flags_ff.first_row ? '0
              : (byp_hit_ff ? byp_data_ff : $signed(ram_rd_data));

      acc = $signed({3'b000, a_pixel_ff, {FRAC_BITS{1'b0}}})
          + $signed({{(ACC_W-ERR_W){re_cur[ERR_W-1]}}, re_cur})
          + $signed({{(ACC_W-ERR_W){row_err[ERR_W-1]}}, row_err});

      priority if (acc[ACC_W-1]) begin
         acc_c = '0;
      end else if (acc > TOP_ACC) begin
         acc_c = TOP_ACC[QW-1:0];
      end else begin
         acc_c = acc[QW-1:0];
      end

      round_sum = acc_c + HALF;
      colour    = fsd_rebuild(round_sum[QW-1:FRAC_BITS], depth);
      err       = $signed({2'b00, acc_c}) - $signed({2'b00, colour, {FRAC_BITS{1'b0}}});

      ex    = {{3{err[ERR_W-1]}}, err};
      m7    = (ex <<< 3) - ex;
      m5    = (ex <<< 2) + ex;
      m3    = (ex <<< 1) + ex;
      m7_sh = m7 >>> 4;
      m5_sh = m5 >>> 4;
      m3_sh = m3 >>> 4;
      e7    = m7_sh[ERR_W-1:0];
      e5    = m5_sh[ERR_W-1:0];
      e3    = m3_sh[ERR_W-1:0];
      e1    = err >>> 4;

      prim_we   = a_col_ff != '0;
      prim_addr = a_col_ff - COL_W'(1);
      prim_data = bl_cur + e3;
      tail_data = bp_cur + e5;

      ram_wr_en   = a_adv && (prim_we || pend_valid_ff);
      ram_wr_addr = prim_we ? prim_addr : pend_addr_ff;
      ram_wr_data = prim_we ? prim_data : pend_data_ff;

      // carries and deferred write
      re_in         = re_ff;
      bl_in         = bl_ff;
      bp_in         = bp_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      if (a_adv) begin
         if (a_flags_ff.row_end) begin
            re_in         = '0;
            bl_in         = '0;
            bp_in         = '0;
            pend_valid_in = 1'b1;
            pend_addr_in  = a_col_ff;
            pend_data_in  = tail_data;
         end else begin
            re_in = e7;
            bl_in = tail_data;
            bp_in = e1;
            if (!prim_we) begin
               pend_valid_in = 1'b0;
            end
         end
      end

      // stage a load, with bypass of writes the ram read misses
      a_valid_in  = a_valid_ff;
      a_pixel_in  = a_pixel_ff;
      a_col_in    = a_col_ff;
      a_flags_in  = a_flags_ff;
      byp_hit_in  = byp_hit_ff;
      byp_data_in = byp_data_ff;
      if (accept) begin
         a_valid_in = 1'b1;
         a_pixel_in = in_pixel;
         a_col_in   = in_col;
         a_flags_in = in_flags;
         priority if (a_adv && a_flags_ff.row_end && a_col_ff == in_col) begin
            byp_hit_in  = 1'b1;
            byp_data_in = tail_data;
         end else if (a_adv && prim_we && prim_addr == in_col) begin
            byp_hit_in  = 1'b1;
            byp_data_in = prim_data;
         end else if (pend_valid_ff && pend_addr_ff == in_col) begin
            byp_hit_in  = 1'b1;
            byp_data_in = pend_data_ff;
         end else begin
            byp_hit_in  = 1'b0;
         end
      end else if (a_adv) begin
         a_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      if (a_adv) begin
         out_valid_in = 1'b1;
         out_pixel_in = colour;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         re_ff         <= '0;
         bl_ff         <= '0;
         bp_ff         <= '0;
      end else begin
         a_valid_ff    <= a_valid_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
         re_ff         <= re_in;
         bl_ff         <= bl_in;
         bp_ff         <= bp_in;
      end
   end

   always_ff @(posedge clock) begin
      a_pixel_ff   <= a_pixel_in;
      a_col_ff     <= a_col_in;
      a_flags_ff   <= a_flags_in;
      byp_hit_ff   <= byp_hit_in;
      byp_data_ff  <= byp_data_in;
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      out_pixel_ff <= out_pixel_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;

endmodule

`default_nettype wire

[src/floyd_steinberg_dither.sv]
// ----------------------------------------------------------------------------
// floyd_steinberg_dither
// Floyd-Steinberg error-diffusion dither for 8-bit grey pixels in raster order.
//
// Input channel req_*: one pixel per beat, req_frame_start marks the first
// pixel of a frame and restarts row and column. Result channel rsp_*: one
// dithered pixel per input beat, in order. Configuration channel csr_*:
// index 0 is the image width, index 1 the kept bit depth; csr_ready is always
// high. The user must make writes while the block is idle; it is unchecked.
// Throughput is one pixel per cycle while the receiver does not stall: the
// right-neighbor error carry closes through the quantize stage, and the row
// error memory takes one read and one write each cycle. The result is held in
// the quantize stage and output registers. The row-end write is deferred into
// the next pixel's cycle, which never writes; reads bypass in-flight entries.
// Reset clears the counters and carries; the row memory is not cleared, the
// first row after reset or after a frame start does not read it.
// When the receiver stalls, the result holds in the output register and one
// more pixel is taken into the quantize stage before req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module floyd_steinberg_dither #(
   parameter int MAX_WIDTH           = fsd_pkg::MAX_WIDTH_DEF,
   parameter int ERROR_FRACTION_BITS = fsd_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_frame_start,
   input  wire logic [fsd_pkg::PIXEL_W-1:0]     req_pixel_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [fsd_pkg::PIXEL_W-1:0]          rsp_pixel_out,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [fsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fsd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fsd_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = COL_W + 1;
   localparam int ERR_W = ERROR_FRACTION_BITS + 10;

   logic [WID_W-1:0]       width_eff;
   logic [BIT_DEPTH_W-1:0] depth_eff;
   logic                   accept;
   logic [COL_W-1:0]       col;
   item_flags_type         flags;
   logic [ERR_W-1:0]       ram_rd_data;
   logic                   ram_wr_en;
   logic [COL_W-1:0]       ram_wr_addr;
   logic [ERR_W-1:0]       ram_wr_data;

   assign accept = req_valid && req_ready;

   fsd_csr #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .width_eff (width_eff),
      .depth_eff (depth_eff)
   );

   fsd_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_frame_start),
      .width_eff   (width_eff),
      .col         (col),
      .flags       (flags)
   );

   fsd_row_ram #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (ERR_W)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (col),
      .rd_data (ram_rd_data)
   );

   fsd_diffuse #(
      .COL_W     (COL_W),
      .FRAC_BITS (ERROR_FRACTION_BITS)
   ) u_diffuse (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_ready      (req_ready),
      .in_col        (col),
      .in_flags      (flags),
      .in_pixel      (req_pixel_in),
      .depth         (depth_eff),
      .ram_rd_data   (ram_rd_data),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out)
   );

endmodule

`default_nettype wire

[src/fsd_checker.sv]
// ----------------------------------------------------------------------------
// fsd_checker
// Port-level checks on the dither block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [fsd_pkg::PIXEL_W-1:0] rsp_pixel_out
);
   import fsd_pkg::*;

   // beats taken in but not yet delivered
   logic [2:0] inflight_ff, inflight_in;

   always_comb begin
      inflight_in = inflight_ff + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_ready_when_out_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output register is free");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out))
      else $error("stalled result beat changed or dropped");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 3'd0)
      else $error("result beat without a pending input beat");

   a_two_deep: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 3'd2)
      else $error("more beats in flight than pipeline stages");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind floyd_steinberg_dither fsd_checker u_checker (.*);

`default_nettype wire

[test/floyd_steinberg_dither_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// floyd_steinberg_dither_tb
// Self-checking bench for the Floyd-Steinberg error-diffusion dither block.
//
// A clocked driver sends pixel beats from a queue that the stimulus process
// fills, and a clocked monitor compares every dithered beat with an in-bench
// model of the error diffusion. Image width and bit depth are rewritten
// between phases while the block is idle, out-of-range values included. One
// phase runs at the widest row setting. Both channels stall at random, with
// one stretch that does not stall.
// ---------------------------------------------------------------------------
module floyd_steinberg_dither_tb;
   import fsd_pkg::*;

   localparam int MAX_COLS    = MAX_WIDTH_DEF;
   localparam int FRAC        = FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic               frame_start;
      logic [PIXEL_W-1:0] pixel;
   } pixel_beat_type;

   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_frame_start = 1'b0;
   logic [PIXEL_W-1:0]     req_pixel_in    = '0;
   logic                   rsp_ready       = 1'b0;
   logic                   csr_valid       = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index       = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata       = '0;
   logic                   req_ready;
   logic                   rsp_valid;
   logic [PIXEL_W-1:0]     rsp_pixel_out;
   logic                   csr_ready;

   floyd_steinberg_dither dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_frame_start (req_frame_start),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [IMAGE_WIDTH_W-1:0] width_reg = IMAGE_WIDTH_W'(IMAGE_WIDTH_RESET);
   logic [BIT_DEPTH_W-1:0]   depth_reg = BIT_DEPTH_W'(BIT_DEPTH_RESET);
   int                       row_errors [MAX_COLS];
   int                       carry_right      = 0;
   int                       carry_below_left = 0;
   int                       carry_below      = 0;
   int                       col_pos          = 0;
   bit                       on_first_row     = 1'b1;

   // stimulus-side view of the row walk, so no unwritten row entry is read
   int                       plan_col        = 0;
   bit                       plan_first_row  = 1'b1;
   bit                       plan_written [MAX_COLS];

   pixel_beat_type           pending_pixels [$];
   logic [PIXEL_W-1:0]       expected_levels [$];
   pixel_beat_type           beat;
   logic [PIXEL_W-1:0]       want_level;
   bit                       steady       = 1'b0;
   int                       queued_count  = 0;
   int                       checked_count = 0;
   int                       fail_count    = 0;
   int                       frames_seen   = 0;
   int                       csr_writes    = 0;
   int                       cycle_count   = 0;

   function automatic int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_COLS) return MAX_COLS;
      return int'(width_reg);
   endfunction

   function automatic int eff_depth();
      if (depth_reg == 0) return 1;
      if (depth_reg > BIT_DEPTH_MAX) return BIT_DEPTH_MAX;
      return int'(depth_reg);
   endfunction

   function automatic logic [PIXEL_W-1:0] replicate_top_bits(logic [PIXEL_W-1:0] q, int b);
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] r;
      int                 s;
      top = q & (8'hFF << (PIXEL_W - b));
      r   = top;
      for (s = b; s <= PIXEL_W; s += b) begin
         r = r | (top >> s);
      end
      return r;
   endfunction

   // quantize one pixel and diffuse its error, returns the dithered level
   function automatic logic [PIXEL_W-1:0] diffuse_pixel(logic fs, logic [PIXEL_W-1:0] px);
      int                 acc;
      int                 err;
      int                 col;
      int                 q;
      int                 e7;
      int                 e5;
      int                 e3;
      int                 e1;
      logic [PIXEL_W-1:0] level;
      if (fs) begin
         col_pos          = 0;
         on_first_row     = 1'b1;
         carry_right      = 0;
         carry_below_left = 0;
         carry_below      = 0;
      end
      col = col_pos;
      if (col >= MAX_COLS) col = MAX_COLS - 1;
      acc = int'(px) * (1 << FRAC) + carry_right;
      if (!on_first_row) acc += row_errors[col];
      if (acc < 0) acc = 0;
      if (acc > 255 * (1 << FRAC)) acc = 255 * (1 << FRAC);
      q = (acc + (1 << (FRAC - 1))) >>> FRAC;
      if (q > 255) q = 255;
      level = replicate_top_bits(PIXEL_W'(q), eff_depth());
      err   = acc - int'(level) * (1 << FRAC);
      e7 = (err * 7) >>> 4;
      e5 = (err * 5) >>> 4;
      e3 = (err * 3) >>> 4;
      e1 = err >>> 4;
      if (col > 0) row_errors[col - 1] = carry_below_left + e3;
      if (col + 1 >= eff_width()) begin
         row_errors[col]  = carry_below + e5;
         carry_right      = 0;
         carry_below_left = 0;
         carry_below      = 0;
         col_pos          = 0;
         on_first_row     = 1'b0;
      end else begin
         carry_right      = e7;
         carry_below_left = carry_below + e5;
         carry_below      = e1;
         col_pos          = col + 1;
      end
      return level;
   endfunction

   // queue a beat, forcing a frame start where the next row would be unwritten
   function automatic void queue_pixel(logic fs, logic [PIXEL_W-1:0] px);
      pixel_beat_type b;
      if (fs || (!plan_first_row && !plan_written[plan_col])) begin
         fs             = 1'b1;
         plan_col       = 0;
         plan_first_row = 1'b1;
      end
      if (plan_col > 0) plan_written[plan_col - 1] = 1'b1;
      if (plan_col + 1 >= eff_width()) begin
         plan_written[plan_col] = 1'b1;
         plan_col               = 0;
         plan_first_row         = 1'b0;
      end else begin
         plan_col++;
      end
      b.frame_start = fs;
      b.pixel       = px;
      pending_pixels.push_back(b);
      queued_count++;
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(9))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return PIXEL_W'($urandom_range(1, 4));
         3:       return PIXEL_W'($urandom_range(251, 254));
         4:       return PIXEL_W'($urandom_range(120, 136));
         default: return PIXEL_W'($urandom_range(255));
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch: %s", msg);
      fail_count++;
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, int val);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom_range(65535));
      if (idx == CSR_IMAGE_WIDTH) data[IMAGE_WIDTH_W-1:0] = IMAGE_WIDTH_W'(val);
      else data[BIT_DEPTH_W-1:0] = BIT_DEPTH_W'(val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) width_reg = data[IMAGE_WIDTH_W-1:0];
      else depth_reg = data[BIT_DEPTH_W-1:0];
      csr_writes++;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (checked_count < queued_count || pending_pixels.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_phase(int count, int fs_pct);
      int i;
      for (i = 0; i < count; i++) begin
         queue_pixel($urandom_range(99) < fs_pct, pick_pixel());
      end
      wait_drained();
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_levels.push_back(diffuse_pixel(req_frame_start, req_pixel_in));
            if (req_frame_start) frames_seen++;
         end
         if (!req_valid || req_ready) begin
            if (pending_pixels.size() != 0 && (steady || $urandom_range(99) >= 38)) begin
               beat = pending_pixels.pop_front();
               req_valid       <= 1'b1;
               req_frame_start <= beat.frame_start;
               req_pixel_in    <= beat.pixel;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               report_mismatch($sformatf("result beat %0d with nothing pending", checked_count));
            end else begin
               want_level = expected_levels.pop_front();
               if (rsp_pixel_out !== want_level) begin
                  report_mismatch($sformatf("result beat %0d pixel_out %0d, expected %0d",
                                            checked_count, rsp_pixel_out, want_level));
               end
            end
            checked_count++;
         end
         rsp_ready <= steady || ($urandom_range(99) >= 38);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int ph;
      int i;
      int w;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: first row of a wide image, extremes of the pixel
      queue_pixel(1'b1, 8'd0);
      queue_pixel(1'b0, 8'd255);
      queue_pixel(1'b0, 8'd128);
      queue_pixel(1'b0, 8'd127);
      queue_pixel(1'b0, 8'd1);
      queue_pixel(1'b0, 8'd254);
      wait_drained();

      // width and depth of zero act as one: every pixel ends a row
      write_csr(CSR_IMAGE_WIDTH, 0);
      write_csr(CSR_BIT_DEPTH, 0);
      queue_pixel(1'b0, 8'd128);
      queue_pixel(1'b0, 8'd127);
      queue_pixel(1'b0, 8'd200);
      queue_pixel(1'b0, 8'd0);
      queue_pixel(1'b0, 8'd255);
      wait_drained();

      // depth above eight acts as eight, frame start in the second row
      write_csr(CSR_IMAGE_WIDTH, 3);
      write_csr(CSR_BIT_DEPTH, 15);
      queue_pixel(1'b1, 8'd255);
      queue_pixel(1'b0, 8'd0);
      queue_pixel(1'b0, 8'd255);
      queue_pixel(1'b0, 8'd1);
      queue_pixel(1'b1, 8'd200);
      queue_pixel(1'b0, 8'd3);
      queue_pixel(1'b0, 8'd250);
      wait_drained();

      // three bits kept, frame start mid-row drops the partials
      write_csr(CSR_IMAGE_WIDTH, 5);
      write_csr(CSR_BIT_DEPTH, 3);
      for (i = 0; i < 7; i++) queue_pixel(1'b0, PIXEL_W'(37 * i + 10));
      queue_pixel(1'b1, 8'd99);
      queue_pixel(1'b0, 8'd77);
      wait_drained();

      // random phases with fresh settings each time
      for (ph = 0; ph < 10; ph++) begin
         case ($urandom_range(9))
            0:       w = 1;
            1:       w = 2;
            2:       w = 0;
            3:       w = 4095;
            4:       w = $urandom_range(3, 8);
            5:       w = $urandom_range(9, 40);
            default: w = $urandom_range(1, 16);
         endcase
         if ($urandom_range(1)) begin
            write_csr(CSR_IMAGE_WIDTH, w);
            write_csr(CSR_BIT_DEPTH, $urandom_range(15));
         end else begin
            write_csr(CSR_BIT_DEPTH, $urandom_range(15));
            write_csr(CSR_IMAGE_WIDTH, w);
         end
         steady = (ph == 4);
         random_phase(55, 3);
         steady = 1'b0;
      end

      // the largest width, first row only
      write_csr(CSR_IMAGE_WIDTH, MAX_COLS);
      write_csr(CSR_BIT_DEPTH, $urandom_range(1, 8));
      queue_pixel(1'b1, pick_pixel());
      random_phase(75, 0);

      repeat (20) @(posedge clock);
      if (expected_levels.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_levels.size()));
      end

      $display("run covered %0d pixel beats in %0d frames with %0d register writes",
               checked_count, frames_seen, csr_writes);
      $display("widths from one to the full row, depths zero to fifteen, %0d mismatches",
               fail_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
